@@ hw/rtl/fbf_pkg.sv @@
// Shared types and constants for the flow-controlled byte FIFO.
package fbf_pkg;

   localparam int OP_W        = 3;
   localparam int BYTE_W      = 8;
   localparam int CNT_W       = 7;
   localparam int OCC_W       = 11;
   localparam int TOT_W       = 32;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 104;
   localparam int RSP_PAD_W   = RSP_TDATA_W - (BYTE_W + 1 + 2 * OCC_W + 2 * TOT_W + 2);

   // Operation codes
   localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
   localparam logic [OP_W-1:0] OP_READ  = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP   = 3'd3;
   localparam logic [OP_W-1:0] OP_END   = 3'd4;
   localparam logic [OP_W-1:0] OP_NOP   = 3'd5;

   localparam logic [OCC_W-1:0] CAP_RESET = 11'd1024;

   // Classified command handed from the front to the back
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] byte_value;
      logic [CNT_W-1:0]  count;
   } cmd_type;

   // Result payload, last field in the lowest bits
   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic                 end_of_stream;
      logic                 ended_flag;
      logic [TOT_W-1:0]     total_read;
      logic [TOT_W-1:0]     total_written;
      logic [OCC_W-1:0]     free_space;
      logic [OCC_W-1:0]     occupancy;
      logic                 accepted;
      logic [BYTE_W-1:0]    data_byte;
   } rsp_data_type;

endpackage

@@ hw/rtl/fbf_front.sv @@
// Front part: accepts request transactions, classifies them and queues them.
module fbf_front #(
   parameter int MAX_BURST = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fbf_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [fbf_pkg::OP_W-1:0]         req_tuser,
   output logic                             cmd_valid,
   input  logic                             cmd_pop,
   output fbf_pkg::cmd_type                 cmd
);

   fbf_pkg::cmd_type           q_ff [2];
   logic                       wr_ptr_ff, wr_ptr_in;
   logic                       rd_ptr_ff, rd_ptr_in;
   logic [1:0]                 cnt_ff, cnt_in;
   fbf_pkg::cmd_type           cls;
   logic [fbf_pkg::CNT_W-1:0]  req_cnt;
   logic                       push;
   logic                       pop;

   // Classify: normalize the operation and saturate the count
   assign req_cnt = req_tdata[8 +: fbf_pkg::CNT_W];

   always_comb begin
      cls.byte_value = req_tdata[fbf_pkg::BYTE_W-1:0];
      cls.count      = (req_cnt > fbf_pkg::CNT_W'(MAX_BURST)) ?
                       fbf_pkg::CNT_W'(MAX_BURST) : req_cnt;
      case (req_tuser)
         fbf_pkg::OP_WRITE,
         fbf_pkg::OP_READ,
         fbf_pkg::OP_PEEK,
         fbf_pkg::OP_POP,
         fbf_pkg::OP_END: cls.op = req_tuser;
         default:         cls.op = fbf_pkg::OP_NOP;
      endcase
   end

   // Two-entry queue between the front and the back
   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign pop        = cmd_pop && cmd_valid;
   assign cmd        = q_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the classified transaction
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

@@ hw/rtl/fbf_back.sv @@
// Back part: byte store, pointers, totals and the result register.
module fbf_back #(
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   output logic                             cmd_pop,
   input  fbf_pkg::cmd_type                 cmd,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fbf_pkg::OCC_W-1:0]        csr_data,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output fbf_pkg::rsp_data_type            rsp_data,
   output logic                             rsp_tlast,
   output logic                             rsp_tuser
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW = ((PW > fbf_pkg::OCC_W) ? PW : fbf_pkg::OCC_W) + 1;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_STREAM = 1'b1;

   logic [fbf_pkg::BYTE_W-1:0] mem [DEPTH];

   logic [PW-1:0]               head_ff, head_in;
   logic [fbf_pkg::OCC_W-1:0]   fill_ff, fill_in;
   logic [fbf_pkg::TOT_W-1:0]   wtot_ff, wtot_in;
   logic [fbf_pkg::TOT_W-1:0]   rtot_ff, rtot_in;
   logic                        ended_ff, ended_in;
   logic [fbf_pkg::OCC_W-1:0]   cap_ff, cap_in;
   logic                        state_ff, state_in;
   logic [PW-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [fbf_pkg::CNT_W-1:0]   iss_left_ff, iss_left_in;
   logic [fbf_pkg::CNT_W-1:0]   emit_left_ff, emit_left_in;
   logic                        pend_ff, pend_in;
   logic [fbf_pkg::BYTE_W-1:0]  rd_data_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   fbf_pkg::rsp_data_type       rsp_ff;
   logic                        rsp_last_ff;
   logic                        rsp_dv_ff;

   logic [fbf_pkg::OCC_W-1:0]   eff_cap;
   logic [fbf_pkg::CNT_W-1:0]   n;
   logic [SW-1:0]               tail_sum, head_sum, rd_sum;
   logic [PW-1:0]               tail, head_adv, rd_adv;
   logic                        out_free;
   logic                        go;
   logic                        wr_en;
   logic                        rd_en;
   logic                        emit;
   logic                        load;
   logic                        ld_last;
   logic                        ld_dv;
   logic                        ld_acc;
   logic [fbf_pkg::BYTE_W-1:0]  ld_byte;

   // Configuration is always taken
   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid) ? csr_data : cap_ff;

   // Limit the capacity to the store depth
   assign eff_cap = (32'(cap_ff) > 32'(DEPTH)) ? fbf_pkg::OCC_W'(DEPTH) : cap_ff;

   // Bytes to act on: requested count limited by occupancy
   assign n = (fbf_pkg::OCC_W'(cmd.count) < fill_ff) ? cmd.count :
              fbf_pkg::CNT_W'(fill_ff);

   // Pointer arithmetic, wrapping at the store depth
   assign tail_sum = SW'(head_ff) + SW'(fill_ff);
   assign tail     = PW'((tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum);
   assign head_sum = SW'(head_ff) + SW'(n);
   assign head_adv = PW'((head_sum >= SW'(DEPTH)) ? head_sum - SW'(DEPTH) : head_sum);
   assign rd_sum   = SW'(rd_ptr_ff) + SW'(1);
   assign rd_adv   = PW'((rd_sum >= SW'(DEPTH)) ? rd_sum - SW'(DEPTH) : rd_sum);

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign go       = (state_ff == ST_IDLE) && cmd_valid && out_free;
   assign cmd_pop  = go;

   // Stream reads: issue while the read register can move on
   assign rd_en = (state_ff == ST_STREAM) && (iss_left_ff != '0) && (!pend_ff || out_free);
   assign emit  = (state_ff == ST_STREAM) && pend_ff && out_free;

   // Execute one command or advance the stream
   always_comb begin
      head_in      = head_ff;
      fill_in      = fill_ff;
      wtot_in      = wtot_ff;
      rtot_in      = rtot_ff;
      ended_in     = ended_ff;
      state_in     = state_ff;
      rd_ptr_in    = rd_ptr_ff;
      iss_left_in  = iss_left_ff;
      emit_left_in = emit_left_ff;
      wr_en        = 1'b0;
      load         = 1'b0;
      ld_last      = 1'b1;
      ld_dv        = 1'b0;
      ld_acc       = 1'b0;
      ld_byte      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               case (cmd.op)
                  fbf_pkg::OP_WRITE: begin
                     load   = 1'b1;
                     ld_acc = (fill_ff < eff_cap);
                     if (fill_ff < eff_cap) begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + fbf_pkg::OCC_W'(1);
                        wtot_in = wtot_ff + 32'd1;
                     end
                  end
                  fbf_pkg::OP_READ,
                  fbf_pkg::OP_PEEK: begin
                     if (n == '0) begin
                        load = 1'b1;
                     end else begin
                        state_in     = ST_STREAM;
                        rd_ptr_in    = head_ff;
                        iss_left_in  = n;
                        emit_left_in = n;
                        if (cmd.op == fbf_pkg::OP_READ) begin
                           head_in = head_adv;
                           fill_in = fill_ff - fbf_pkg::OCC_W'(n);
                           rtot_in = rtot_ff + 32'(n);
                        end
                     end
                  end
                  fbf_pkg::OP_POP: begin
                     load    = 1'b1;
                     head_in = head_adv;
                     fill_in = fill_ff - fbf_pkg::OCC_W'(n);
                     rtot_in = rtot_ff + 32'(n);
                  end
                  fbf_pkg::OP_END: begin
                     load     = 1'b1;
                     ended_in = 1'b1;
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         ST_STREAM: begin
            if (rd_en) begin
               rd_ptr_in   = rd_adv;
               iss_left_in = iss_left_ff - fbf_pkg::CNT_W'(1);
            end
            if (emit) begin
               load         = 1'b1;
               ld_dv        = 1'b1;
               ld_byte      = rd_data_ff;
               ld_last      = (emit_left_ff == fbf_pkg::CNT_W'(1));
               emit_left_in = emit_left_ff - fbf_pkg::CNT_W'(1);
               if (emit_left_ff == fbf_pkg::CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign pend_in      = rd_en || (pend_ff && !out_free);
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         wtot_ff      <= '0;
         rtot_ff      <= '0;
         ended_ff     <= 1'b0;
         cap_ff       <= fbf_pkg::CAP_RESET;
         state_ff     <= ST_IDLE;
         iss_left_ff  <= '0;
         emit_left_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         wtot_ff      <= wtot_in;
         rtot_ff      <= rtot_in;
         ended_ff     <= ended_in;
         cap_ff       <= cap_in;
         state_ff     <= state_in;
         iss_left_ff  <= iss_left_in;
         emit_left_ff <= emit_left_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Read cursor
   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
   end

   // Byte store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail] <= cmd.byte_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   // Result register, status taken after the operation
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff.pad           <= '0;
         rsp_ff.data_byte     <= ld_byte;
         rsp_ff.accepted      <= ld_acc;
         rsp_ff.occupancy     <= fill_in;
         rsp_ff.free_space    <= (eff_cap > fill_in) ? eff_cap - fill_in : '0;
         rsp_ff.total_written <= wtot_in;
         rsp_ff.total_read    <= rtot_in;
         rsp_ff.ended_flag    <= ended_in;
         rsp_ff.end_of_stream <= ended_in && (fill_in == '0);
         rsp_last_ff          <= ld_last;
         rsp_dv_ff            <= ld_dv;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_dv_ff;

endmodule

@@ hw/rtl/flow_controlled_byte_fifo_core.sv @@
// Top level of the flow-controlled byte FIFO.
//
//   channel  ports                  direction  carries
//   req      req_tvalid/tready      in         operation (tuser), byte and count (tdata)
//   rsp      rsp_tvalid/tready      out        returned byte and status (tdata), data_valid
//                                              (tuser), final result of a transaction (tlast)
//   csr      csr_valid/ready        in         capacity_in_use (csr_data)
//
// Write, pop, end and unknown operations are handled in the back part and give one result.
// A read or peek of n > 0 bytes takes the command and issues the first store read in the next
// cycle, then gives n results at one byte per cycle while the result side is not stalled,
// paced by the single read port of the byte store; the next operation starts after the last.
// Reset clears head and queue pointers, counts, totals, end flag, not store or read cursor.
// A two-entry queue lets requests arrive while the back part is busy or the result stalls.
module flow_controlled_byte_fifo_core #(
   parameter int DEPTH     = 1024,
   parameter int MAX_BURST = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [7:0] byte_value, [14:8] count, [15] zero
   input  logic [fbf_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [2:0] operation
   input  logic [fbf_pkg::OP_W-1:0]         req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] data_byte, [8] accepted, [19:9] occupancy, [30:20] free_space,
   // [62:31] total_written, [94:63] total_read, [95] end-of-input flag,
   // [96] end_of_stream, [103:97] zero
   output logic [fbf_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   // [0] data_valid
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fbf_pkg::OCC_W-1:0]        csr_data
);

   logic                   cmd_valid;
   logic                   cmd_pop;
   fbf_pkg::cmd_type       cmd;
   fbf_pkg::rsp_data_type  rsp_data;

   fbf_front #(
      .MAX_BURST (MAX_BURST)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd        (cmd)
   );

   fbf_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd        (cmd),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assign rsp_tdata = rsp_data;

endmodule

@@ tb/tb_flow_controlled_byte_fifo_core.sv @@
// Testbench for the flow-controlled byte FIFO core, checked against a shadow FIFO model.
module tb_flow_controlled_byte_fifo_core;

   localparam int FIFO_DEPTH    = 1024;
   localparam int BURST_LIMIT   = 64;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_ITEMS   = 40;

   // Opcodes the block must treat as status-only requests
   localparam logic [fbf_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [fbf_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

   typedef struct {
      logic [fbf_pkg::BYTE_W-1:0] data_byte;
      logic                       data_valid;
      logic                       last;
      logic                       accepted;
      logic [fbf_pkg::OCC_W-1:0]  occupancy;
      logic [fbf_pkg::OCC_W-1:0]  free_space;
      logic [fbf_pkg::TOT_W-1:0]  total_written;
      logic [fbf_pkg::TOT_W-1:0]  total_read;
      logic                       ended_flag;
      logic                       end_of_stream;
   } status_beat_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [fbf_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic [fbf_pkg::OP_W-1:0]        req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [fbf_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            rsp_tuser;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [fbf_pkg::OCC_W-1:0]       csr_data;

   // Shadow copy of the FIFO contents, pointers, totals and capacity register
   logic [fbf_pkg::BYTE_W-1:0] shadow_bytes [FIFO_DEPTH];
   int unsigned                shadow_head;
   int unsigned                shadow_fill;
   logic [fbf_pkg::TOT_W-1:0]  shadow_written;
   logic [fbf_pkg::TOT_W-1:0]  shadow_read;
   logic                       shadow_ended;
   logic [fbf_pkg::OCC_W-1:0]  shadow_capacity;

   status_beat_type expected_beats[$];
   int              mismatch_count    = 0;
   int              cycle_count       = 0;
   bit              req_gaps_on       = 1'b1;
   int              rsp_stall_request = 0;
   int              rsp_hold_left     = 0;
   int              rsp_gap_left      = 0;
   int              rsp_run_left      = 0;

   flow_controlled_byte_fifo_core #(
      .DEPTH     (FIFO_DEPTH),
      .MAX_BURST (BURST_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Idle length: mostly none, sometimes a few cycles, rarely a long stretch
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      else if (r < 92) return $urandom_range(1, 3);
      else return $urandom_range(6, 20);
   endfunction

   // Capacity settings above the store depth act as the full depth
   function automatic int unsigned usable_capacity();
      return (shadow_capacity > FIFO_DEPTH) ? FIFO_DEPTH : shadow_capacity;
   endfunction

   function automatic status_beat_type make_beat(logic [fbf_pkg::BYTE_W-1:0] data,
                                                 logic valid, logic is_last, logic stored);
      status_beat_type beat;
      int unsigned     cap;
      cap = usable_capacity();
      beat.data_byte     = data;
      beat.data_valid    = valid;
      beat.last          = is_last;
      beat.accepted      = stored;
      beat.occupancy     = fbf_pkg::OCC_W'(shadow_fill);
      beat.free_space    = (cap > shadow_fill) ? fbf_pkg::OCC_W'(cap - shadow_fill) : '0;
      beat.total_written = shadow_written;
      beat.total_read    = shadow_read;
      beat.ended_flag    = shadow_ended;
      beat.end_of_stream = shadow_ended && (shadow_fill == 0);
      return beat;
   endfunction

   // Append one expected beat at the tail of the queue
   function automatic void queue_beat(status_beat_type beat);
      expected_beats.insert(expected_beats.size(), beat);
   endfunction

   function automatic void drop_bytes(int unsigned n);
      shadow_head = (shadow_head + n) % FIFO_DEPTH;
      shadow_fill -= n;
      shadow_read += n;
   endfunction

   // Update the shadow FIFO for one accepted request and queue the status beats it yields
   task automatic apply_fifo_op(input logic [fbf_pkg::OP_W-1:0] op,
                                input logic [fbf_pkg::BYTE_W-1:0] value,
                                input logic [fbf_pkg::CNT_W-1:0] count);
      int unsigned                want;
      int unsigned                n;
      logic [fbf_pkg::BYTE_W-1:0] taken [BURST_LIMIT];
      logic                       stored;
      want = (count > BURST_LIMIT) ? BURST_LIMIT : count;
      n = (want < shadow_fill) ? want : shadow_fill;
      case (op)
         fbf_pkg::OP_WRITE: begin
            stored = shadow_fill < usable_capacity();
            if (stored) begin
               shadow_bytes[(shadow_head + shadow_fill) % FIFO_DEPTH] = value;
               shadow_fill++;
               shadow_written++;
            end
            queue_beat(make_beat('0, 1'b0, 1'b1, stored));
         end
         fbf_pkg::OP_READ, fbf_pkg::OP_PEEK: begin
            if (n == 0) begin
               queue_beat(make_beat('0, 1'b0, 1'b1, 1'b0));
            end else begin
               for (int i = 0; i < n; i++)
                  taken[i] = shadow_bytes[(shadow_head + i) % FIFO_DEPTH];
               if (op == fbf_pkg::OP_READ) drop_bytes(n);
               for (int i = 0; i < n; i++)
                  queue_beat(make_beat(taken[i], 1'b1, i == n - 1, 1'b0));
            end
         end
         fbf_pkg::OP_POP: begin
            drop_bytes(n);
            queue_beat(make_beat('0, 1'b0, 1'b1, 1'b0));
         end
         fbf_pkg::OP_END: begin
            shadow_ended = 1'b1;
            queue_beat(make_beat('0, 1'b0, 1'b1, 1'b0));
         end
         default: begin
            queue_beat(make_beat('0, 1'b0, 1'b1, 1'b0));
         end
      endcase
   endtask

   function automatic void check_field(string name, logic [fbf_pkg::TOT_W-1:0] want,
                                       logic [fbf_pkg::TOT_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each result transaction with the oldest expected status beat
   always @(posedge clock) begin : rsp_check
      fbf_pkg::rsp_data_type fields;
      status_beat_type       want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         fields = fbf_pkg::rsp_data_type'(rsp_tdata);
         if (expected_beats.size() == 0) begin
            $error("unexpected result transaction: data_byte %0h occupancy %0d",
                   fields.data_byte, fields.occupancy);
            mismatch_count++;
         end else begin
            want = expected_beats[0];
            expected_beats.delete(0);
            check_field("data_byte", want.data_byte, fields.data_byte);
            check_field("data_valid", want.data_valid, rsp_tuser);
            check_field("last", want.last, rsp_tlast);
            check_field("accepted", want.accepted, fields.accepted);
            check_field("occupancy", want.occupancy, fields.occupancy);
            check_field("free_space", want.free_space, fields.free_space);
            check_field("total_written", want.total_written, fields.total_written);
            check_field("total_read", want.total_read, fields.total_read);
            check_field("ended_flag", want.ended_flag, fields.ended_flag);
            check_field("end_of_stream", want.end_of_stream, fields.end_of_stream);
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Pace the result side: random gaps, ready runs, and long holds on request
   initial begin : rsp_pacer
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall_request > 0) begin
            rsp_hold_left = rsp_stall_request;
            rsp_stall_request = 0;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap_left > 0) begin
            rsp_gap_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_run_left > 0) begin
               rsp_run_left--;
            end else begin
               rsp_gap_left = pick_gap();
               rsp_run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                          : $urandom_range(0, 5);
            end
         end
      end
   end

   // Offer one request after a random gap and hold it until it is accepted
   task automatic send_request(input logic [fbf_pkg::OP_W-1:0] op,
                               input logic [fbf_pkg::BYTE_W-1:0] value,
                               input logic [fbf_pkg::CNT_W-1:0] count);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, count, value};
      do @(posedge clock); while (!req_tready);
      apply_fifo_op(op, value, count);
      @(negedge clock);
   endtask

   // Stop offering and wait until every expected result has arrived
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [fbf_pkg::OCC_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      shadow_capacity = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Requests against the empty FIFO, including the unassigned opcodes
   task automatic test_empty_fifo();
      send_request(fbf_pkg::OP_READ, 8'h00, 7'd0);
      send_request(fbf_pkg::OP_PEEK, 8'hFF, 7'd5);
      send_request(fbf_pkg::OP_POP, 8'h00, 7'd127);
      send_request(fbf_pkg::OP_NOP, 8'hFF, 7'd127);
      send_request(OP_SPARE_6, 8'h00, 7'd1);
      send_request(OP_SPARE_7, 8'h55, 7'd64);
   endtask

   // Byte extremes, zero counts, saturated counts and short reads
   task automatic test_byte_paths();
      send_request(fbf_pkg::OP_WRITE, 8'h00, 7'd0);
      send_request(fbf_pkg::OP_WRITE, 8'hFF, 7'd127);
      send_request(fbf_pkg::OP_WRITE, 8'hA5, 7'd0);
      send_request(fbf_pkg::OP_WRITE, 8'h5A, 7'd0);
      send_request(fbf_pkg::OP_WRITE, 8'h01, 7'd0);
      send_request(fbf_pkg::OP_WRITE, 8'h80, 7'd0);
      send_request(fbf_pkg::OP_PEEK, 8'h00, 7'd0);
      send_request(fbf_pkg::OP_PEEK, 8'h00, 7'd3);
      send_request(fbf_pkg::OP_READ, 8'h00, 7'd2);
      send_request(fbf_pkg::OP_POP, 8'h00, 7'd1);
      send_request(fbf_pkg::OP_READ, 8'h00, 7'd127);
      send_request(fbf_pkg::OP_WRITE, 8'h3C, 7'd0);
      send_request(fbf_pkg::OP_WRITE, 8'hC3, 7'd0);
      send_request(fbf_pkg::OP_PEEK, 8'h00, 7'd65);
      send_request(fbf_pkg::OP_READ, 8'h00, 7'd64);
   endtask

   // Capacity register at its extremes, above the depth and below the occupancy
   task automatic test_capacity_settings();
      write_capacity(11'd0);
      send_request(fbf_pkg::OP_WRITE, 8'h11, 7'd0);
      send_request(fbf_pkg::OP_READ, 8'h00, 7'd1);
      write_capacity(11'd2047);
      repeat (5) send_request(fbf_pkg::OP_WRITE, 8'($urandom_range(0, 255)), 7'd0);
      write_capacity(11'd1025);
      send_request(fbf_pkg::OP_WRITE, 8'h22, 7'd0);
      // occupancy now exceeds the capacity: writes refused, free space floors at zero
      write_capacity(11'd1);
      send_request(fbf_pkg::OP_WRITE, 8'h33, 7'd0);
      send_request(fbf_pkg::OP_POP, 8'h00, 7'd5);
      send_request(fbf_pkg::OP_WRITE, 8'h44, 7'd0);
      send_request(fbf_pkg::OP_READ, 8'h00, 7'd1);
      send_request(fbf_pkg::OP_WRITE, 8'h55, 7'd0);
      send_request(fbf_pkg::OP_WRITE, 8'h66, 7'd0);
      write_capacity(11'd3);
      repeat (4) send_request(fbf_pkg::OP_WRITE, 8'($urandom_range(0, 255)), 7'd0);
      send_request(fbf_pkg::OP_READ, 8'h00, 7'd64);
      write_capacity(fbf_pkg::CAP_RESET);
   endtask

   // Hold the result side for a long stretch while requests keep coming
   task automatic test_output_backpressure();
      drain_results();
      req_gaps_on = 1'b0;
      rsp_stall_request = 300;
      repeat (12) send_request(fbf_pkg::OP_WRITE, 8'($urandom_range(0, 255)), 7'd0);
      send_request(fbf_pkg::OP_READ, 8'h00, 7'd10);
      send_request(fbf_pkg::OP_PEEK, 8'h00, 7'd5);
      send_request(fbf_pkg::OP_POP, 8'h00, 7'd2);
      send_request(fbf_pkg::OP_READ, 8'h00, 7'd64);
      drain_results();
      req_gaps_on = 1'b1;
   endtask

   // Random operation mix over several capacity settings
   task automatic test_random_traffic();
      logic [fbf_pkg::OP_W-1:0]   op;
      logic [fbf_pkg::BYTE_W-1:0] value;
      logic [fbf_pkg::CNT_W-1:0]  count;
      int                         r;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       write_capacity(fbf_pkg::CAP_RESET);
            1:       write_capacity(fbf_pkg::OCC_W'($urandom_range(2, 12)));
            2:       write_capacity(11'd2047);
            default: write_capacity(fbf_pkg::OCC_W'($urandom_range(0, 40)));
         endcase
         req_gaps_on = (phase % 2 == 0);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 50) op = fbf_pkg::OP_WRITE;
            else if (r < 70) op = fbf_pkg::OP_READ;
            else if (r < 82) op = fbf_pkg::OP_PEEK;
            else if (r < 92) op = fbf_pkg::OP_POP;
            else begin
               case ($urandom_range(0, 2))
                  0:       op = fbf_pkg::OP_NOP;
                  1:       op = OP_SPARE_6;
                  default: op = OP_SPARE_7;
               endcase
            end
            value = fbf_pkg::BYTE_W'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (r < 70) count = fbf_pkg::CNT_W'($urandom_range(0, 8));
            else if (r < 92) count = fbf_pkg::CNT_W'($urandom_range(9, 64));
            else count = fbf_pkg::CNT_W'($urandom_range(65, 127));
            send_request(op, value, count);
            // occasionally pause the sender until every result is back
            if ($urandom_range(0, 39) == 0) drain_results();
         end
      end
      req_gaps_on = 1'b1;
   endtask

   // End of input: flag set, writes still accepted, end of stream once emptied
   task automatic test_end_of_input();
      write_capacity(fbf_pkg::CAP_RESET);
      send_request(fbf_pkg::OP_END, 8'h00, 7'd0);
      send_request(fbf_pkg::OP_WRITE, 8'h77, 7'd0);
      while (shadow_fill > 0) send_request(fbf_pkg::OP_READ, 8'h00, 7'd64);
      send_request(fbf_pkg::OP_END, 8'h00, 7'd0);
      send_request(fbf_pkg::OP_PEEK, 8'h00, 7'd4);
      send_request(fbf_pkg::OP_POP, 8'h00, 7'd4);
      send_request(fbf_pkg::OP_WRITE, 8'h88, 7'd0);
      send_request(fbf_pkg::OP_READ, 8'h00, 7'd1);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      shadow_head     = 0;
      shadow_fill     = 0;
      shadow_written  = '0;
      shadow_read     = '0;
      shadow_ended    = 1'b0;
      shadow_capacity = fbf_pkg::CAP_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_fifo();
      test_byte_paths();
      test_capacity_settings();
      test_output_backpressure();
      test_random_traffic();
      test_end_of_input();

      drain_results();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
